@@ hdl/ddo_pkg.sv @@
package ddo_pkg;

	localparam int ANGLE_BITS_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int COUNT_W   = 32;
	localparam int POS_W     = 32;
	localparam int HEAD_W    = 16;
	localparam int DPC_W     = 24;
	localparam int TPS_W     = 14;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 24;

	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int SAT_W   = 66;

	localparam int TRIG_W   = 32;
	localparam int CORDIC_W = 34;
	localparam logic signed [CORDIC_W-1:0] KINV_Q30 = 34'sd652032874;

	localparam logic [DPC_W-1:0]  DPC_RST = 24'd323052;
	localparam logic [HEAD_W-1:0] OFS_RST = 16'd0;
	localparam logic [TPS_W-1:0]  TPS_RST = 14'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIST_PER_COUNT   = 2'd0,
		REG_HEADING_OFFSET   = 2'd1,
		REG_TICKS_PER_SECOND = 2'd2
	} reg_idx_t;

	// arctangent of 2^-i in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	function automatic logic signed [POS_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if ((&v[SAT_W-1:POS_W-1]) || !(|v[SAT_W-1:POS_W-1])) begin
			r = v[POS_W-1:0];
		end else if (v[SAT_W-1]) begin
			r = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(POS_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

@@ hdl/ddo_mul.sv @@
module ddo_mul
	import ddo_pkg::*;
(
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule

@@ hdl/ddo_cordic.sv @@
module ddo_cordic
	import ddo_pkg::*;
#(
	parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [ANGLE_BITS-1:0]    angle,
	output logic                     busy,
	output logic signed [TRIG_W-1:0] cos_val,
	output logic signed [TRIG_W-1:0] sin_val
);

	localparam int ZW    = ANGLE_BITS + 2;
	localparam int IDX_W = $clog2(CORDIC_STEPS);
	localparam logic signed [ZW-1:0] QUARTER = ZW'(1) << (ANGLE_BITS - 2);
	localparam logic signed [ZW-1:0] HALF    = ZW'(1) << (ANGLE_BITS - 1);

	logic signed [CORDIC_W-1:0] x_q, y_q, x_init, xs, ys;
	logic signed [ZW-1:0]       z_q, z0, z_init, a;
	logic [IDX_W-1:0]           idx_q;
	logic                       busy_q;

	// fold into +/- quarter turn with a half-turn flip
	always_comb begin
		z0 = ZW'($signed(angle));
		z_init = z0;
		x_init = KINV_Q30;
		if (z0 > QUARTER) begin
			z_init = z0 - HALF;
			x_init = -KINV_Q30;
		end else if (z0 < -QUARTER) begin
			z_init = z0 + HALF;
			x_init = -KINV_Q30;
		end
	end

	assign xs = x_q >>> idx_q;
	assign ys = y_q >>> idx_q;
	assign a  = $signed(ZW'(atan_turn(5'(idx_q)) >> (32 - ANGLE_BITS)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q) begin
			idx_q <= idx_q + 1'b1;
			if (idx_q == IDX_W'(CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x_init;
			y_q <= '0;
			z_q <= z_init;
		end else if (busy_q) begin
			if (!z_q[ZW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - a;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + a;
			end
		end
	end

	assign busy    = busy_q;
	assign cos_val = x_q[TRIG_W-1:0];
	assign sin_val = y_q[TRIG_W-1:0];

endmodule

@@ hdl/diff_drive_odometry.sv @@
// Differential-drive odometry. Each input transfer carries two absolute wheel
// counts and an IMU heading; each produces exactly one output transfer with
// the saturated x/y position, the new heading and both wheel velocities. An
// item occupies the block until the next transfer can be accepted: the
// iterative CORDIC sets how long that takes, while the shared 33x32
// multiplier works the distance and velocity products alongside it and then
// the two position products. in_stall stays high while an item is in work; a
// finished result sits in the output register until taken, and the next item
// waits for that register only at its final step.
module diff_drive_odometry
	import ddo_pkg::*;
#(
	parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DAT_W-1:0]     cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [COUNT_W-1:0] left_count,
	input  logic signed [COUNT_W-1:0] right_count,
	input  logic [HEAD_W-1:0]        imu_heading,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [POS_W-1:0]  pos_x,
	output logic signed [POS_W-1:0]  pos_y,
	output logic [HEAD_W-1:0]        pose_angle,
	output logic signed [POS_W-1:0]  vel_left,
	output logic signed [POS_W-1:0]  vel_right
);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_DL   = 10'b0000000010,
		ST_DR   = 10'b0000000100,
		ST_VL   = 10'b0000001000,
		ST_VR   = 10'b0000010000,
		ST_WAIT = 10'b0000100000,
		ST_MC   = 10'b0001000000,
		ST_MS   = 10'b0010000000,
		ST_XA   = 10'b0100000000,
		ST_OUT  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	logic [DPC_W-1:0]  dpc_q;
	logic [HEAD_W-1:0] ofs_q;
	logic [TPS_W-1:0]  tps_q;

	logic [COUNT_W-1:0]       last_left_q, last_right_q;
	logic signed [POS_W-1:0]  x_acc_q, y_acc_q;
	logic [HEAD_W-1:0]        angle_reg_q;
	logic signed [COUNT_W-1:0] delta_l_q, delta_r_q;
	logic signed [POS_W-1:0]  dl_q, dr_q, vl_q, vr_q;
	logic signed [MUL_A_W-1:0] d2_q;
	logic                     out_valid_q;

	logic                     accept, out_free;
	logic [HEAD_W-1:0]        newa, dth;
	logic [16:0]              mid;
	logic [ANGLE_BITS+16:0]   ang_wide;
	logic [ANGLE_BITS-1:0]    ang;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod;
	logic signed [TRIG_W-1:0]  cos_v, sin_v;
	logic                      cordic_busy;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// midpoint heading in 2^-17 turn, rescaled to ANGLE_BITS
	assign newa     = ofs_q - imu_heading;
	assign dth      = newa - angle_reg_q;
	assign mid      = {angle_reg_q, 1'b0} + 17'($signed(dth));
	assign ang_wide = {mid, {ANGLE_BITS{1'b0}}};
	assign ang      = ang_wide[ANGLE_BITS+16:17];

	ddo_cordic #(
		.ANGLE_BITS  (ANGLE_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.angle  (ang),
		.busy   (cordic_busy),
		.cos_val(cos_v),
		.sin_val(sin_v)
	);

	ddo_mul u_mul (
		.clk(clk),
		.a  (mul_a),
		.b  (mul_b),
		.p_q(prod)
	);

	always_comb begin
		mul_a = MUL_A_W'(dr_q);
		mul_b = MUL_B_W'($signed({1'b0, tps_q}));
		unique case (state_q)
			ST_DL: begin
				mul_a = MUL_A_W'(delta_l_q);
				mul_b = MUL_B_W'($signed({1'b0, dpc_q}));
			end
			ST_DR: begin
				mul_a = MUL_A_W'(delta_r_q);
				mul_b = MUL_B_W'($signed({1'b0, dpc_q}));
			end
			ST_VL: begin
				mul_a = MUL_A_W'(dl_q);
				mul_b = MUL_B_W'($signed({1'b0, tps_q}));
			end
			ST_MC: begin
				mul_a = d2_q;
				mul_b = cos_v;
			end
			ST_MS: begin
				mul_a = d2_q;
				mul_b = sin_v;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_DL;
			ST_DL:   state_d = ST_DR;
			ST_DR:   state_d = ST_VL;
			ST_VL:   state_d = ST_VR;
			ST_VR:   state_d = ST_WAIT;
			ST_WAIT: if (!cordic_busy) state_d = ST_MC;
			ST_MC:   state_d = ST_MS;
			ST_MS:   state_d = ST_XA;
			ST_XA:   state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpc_q <= DPC_RST;
			ofs_q <= OFS_RST;
			tps_q <= TPS_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DIST_PER_COUNT:   dpc_q <= cfg_data[DPC_W-1:0];
				REG_HEADING_OFFSET:   ofs_q <= cfg_data[HEAD_W-1:0];
				REG_TICKS_PER_SECOND: tps_q <= cfg_data[TPS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_left_q  <= '0;
			last_right_q <= '0;
			angle_reg_q  <= '0;
			x_acc_q      <= '0;
			y_acc_q      <= '0;
		end else begin
			if (accept) begin
				last_left_q  <= left_count;
				last_right_q <= right_count;
				angle_reg_q  <= newa;
			end
			if (state_q == ST_MS) begin
				y_acc_q <= sat32(SAT_W'(y_acc_q) + SAT_W'(prod >>> 31));
			end
			if (state_q == ST_XA) begin
				x_acc_q <= sat32(SAT_W'(x_acc_q) + SAT_W'(prod >>> 31));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			delta_l_q <= left_count - last_left_q;
			delta_r_q <= right_count - last_right_q;
		end
		if (state_q == ST_DR) dl_q <= sat32(SAT_W'(prod >>> 14));
		if (state_q == ST_VL) dr_q <= sat32(SAT_W'(prod >>> 14));
		if (state_q == ST_VR) vl_q <= sat32(SAT_W'(prod));
		if (state_q == ST_WAIT) begin
			vr_q <= sat32(SAT_W'(prod));
			d2_q <= MUL_A_W'(dl_q) + MUL_A_W'(dr_q);
		end
		if (state_q == ST_OUT && out_free) begin
			pos_x      <= x_acc_q;
			pos_y      <= y_acc_q;
			pose_angle <= angle_reg_q;
			vel_left   <= vl_q;
			vel_right  <= vr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ hdl/ddo_checker.sv @@
module ddo_checker
	import ddo_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [POS_W-1:0]  pos_x,
	input logic signed [POS_W-1:0]  pos_y,
	input logic [HEAD_W-1:0]        pose_angle
);

	// an accepted item keeps the block busy, so new input is refused afterwards
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall)
		else $error("input taken again too soon after a transfer");

	// a new result only appears at the end of an item in work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pos_x) && $stable(pos_y) && $stable(pose_angle))
		else $error("stalled result changed");

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pos_x     (pos_x),
	.pos_y     (pos_y),
	.pose_angle(pose_angle)
);

@@ tb/tb_diff_drive_odometry.sv @@
`timescale 1ns / 100ps

module tb_diff_drive_odometry;
	import ddo_pkg::*;

	localparam int ANG_BITS  = ANGLE_BITS_DEF;
	localparam int ROT_STEPS = (CORDIC_STEPS_DEF < 24) ? CORDIC_STEPS_DEF : 24;
	localparam int ANG_SHIFT = (ANG_BITS >= 17) ? ANG_BITS - 17 : 17 - ANG_BITS;
	localparam longint GAIN_INV_Q30 = 64'sd652032874;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 30;

	localparam logic [31:0] ATAN_STEP [0:23] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

	typedef struct {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [HEAD_W-1:0]       angle;
		logic signed [POS_W-1:0] vl;
		logic signed [POS_W-1:0] vr;
	} pose_t;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [COUNT_W-1:0] left_count = '0;
	logic [COUNT_W-1:0] right_count = '0;
	logic [HEAD_W-1:0] imu_heading = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [POS_W-1:0] pos_x, pos_y, vel_left, vel_right;
	logic [HEAD_W-1:0] pose_angle;

	// predictor state and register copies
	logic [DPC_W-1:0]   dist_scale = DPC_RST;
	logic [HEAD_W-1:0]  head_zero = OFS_RST;
	logic [TPS_W-1:0]   tick_rate = TPS_RST;
	logic [COUNT_W-1:0] odo_last_left = '0;
	logic [COUNT_W-1:0] odo_last_right = '0;
	int                 odo_x = 0;
	int                 odo_y = 0;
	logic [HEAD_W-1:0]  odo_heading = '0;

	pose_t pose_expected[$];

	logic [COUNT_W-1:0] sent_left = '0;
	logic [COUNT_W-1:0] sent_right = '0;
	logic [HEAD_W-1:0]  sent_imu = '0;
	int gap_max = 0;
	int burst_left = 0;
	int fail_count = 0;
	int ticks_sent = 0;
	int poses_checked = 0;
	int settings_used = 0;
	int quiet_cycles = 0;

	logic hold_req = 1'b0;
	logic hold_seen = 1'b0;
	int hold_cnt = 0;
	int mode_left = 0;
	stall_mode_t stall_mode = STALL_NONE;

	diff_drive_odometry dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.left_count(left_count),
		.right_count(right_count),
		.imu_heading(imu_heading),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pose_angle(pose_angle),
		.vel_left(vel_left),
		.vel_right(vel_right)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint clamp32(longint v);
		if (v > S32_MAX) begin
			return S32_MAX;
		end
		if (v < S32_MIN) begin
			return S32_MIN;
		end
		return v;
	endfunction

	function automatic longint wheel_travel(logic [COUNT_W-1:0] cnt, logic [COUNT_W-1:0] prev);
		logic [COUNT_W-1:0] diff;
		diff = cnt - prev;
		return clamp32((longint'(signed'(diff)) * longint'(dist_scale)) >>> 14);
	endfunction

	// rotation-mode CORDIC, angle in 2^-ANG_BITS turn, cos/sin in Q30
	function automatic void rotate(longint ang, output longint c, output longint s);
		longint full, half, quarter, z, x, y, a, xs, ys;
		int i;
		full = longint'(1) << ANG_BITS;
		half = full >>> 1;
		quarter = full >>> 2;
		z = (ang >= half) ? ang - full : ang;
		x = GAIN_INV_Q30;
		y = 0;
		if (z > quarter) begin
			z -= half;
			x = -x;
		end else if (z < -quarter) begin
			z += half;
			x = -x;
		end
		for (i = 0; i < ROT_STEPS; i++) begin
			a = longint'(ATAN_STEP[i] >> (32 - ANG_BITS));
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= a;
			end else begin
				x += ys;
				y -= xs;
				z += a;
			end
		end
		c = x;
		s = y;
	endfunction

	function automatic pose_t advance_pose(logic [COUNT_W-1:0] lc, logic [COUNT_W-1:0] rc,
			logic [HEAD_W-1:0] hd);
		pose_t r;
		longint dl, dr, dth, mid, ang, c, s, d2;
		logic [HEAD_W-1:0] new_head, dth_u;
		dl = wheel_travel(lc, odo_last_left);
		dr = wheel_travel(rc, odo_last_right);
		new_head = head_zero - hd;
		dth_u = new_head - odo_heading;
		dth = longint'(signed'(dth_u));
		mid = (2 * longint'(odo_heading) + dth) & 64'h1FFFF;
		if (ANG_BITS >= 17) begin
			ang = mid << ANG_SHIFT;
		end else begin
			ang = mid >>> ANG_SHIFT;
		end
		rotate(ang, c, s);
		d2 = dl + dr;
		odo_y = int'(clamp32(longint'(odo_y) + ((d2 * c) >>> 31)));
		odo_x = int'(clamp32(longint'(odo_x) + ((d2 * s) >>> 31)));
		odo_heading = new_head;
		odo_last_left = lc;
		odo_last_right = rc;
		r.x = odo_x;
		r.y = odo_y;
		r.angle = new_head;
		r.vl = int'(clamp32(dl * longint'(tick_rate)));
		r.vr = int'(clamp32(dr * longint'(tick_rate)));
		return r;
	endfunction

	function automatic void compare_field(string field, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			fail_count++;
		end
	endfunction

	function automatic logic [COUNT_W-1:0] next_count(logic [COUNT_W-1:0] prev);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return prev + 32'($urandom_range(0, 4000)) - 32'd2000;
		end
		if (r < 85) begin
			return prev + 32'($urandom_range(0, 2097152)) - 32'd1048576;
		end
		if (r < 95) begin
			return $urandom;
		end
		case ($urandom_range(0, 3))
			0: return 32'h00000000;
			1: return 32'h7FFFFFFF;
			2: return 32'h80000000;
			default: return 32'hFFFFFFFF;
		endcase
	endfunction

	function automatic logic [HEAD_W-1:0] next_heading(logic [HEAD_W-1:0] prev);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return prev + 16'($urandom_range(0, 1200)) - 16'd600;
		end
		if (r < 85) begin
			return 16'($urandom);
		end
		if (r < 95) begin
			return prev + 16'h8000 + 16'($urandom_range(0, 8)) - 16'd4;
		end
		case ($urandom_range(0, 3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			default: return 16'h7FFF;
		endcase
	endfunction

	task automatic send_tick(logic [COUNT_W-1:0] lc, logic [COUNT_W-1:0] rc,
			logic [HEAD_W-1:0] hd);
		if (gap_max > 0) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				in_valid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
			end
			burst_left--;
		end
		in_valid <= 1'b1;
		left_count <= lc;
		right_count <= rc;
		imu_heading <= hd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pose_expected.push_back(advance_pose(lc, rc, hd));
		sent_left = lc;
		sent_right = rc;
		sent_imu = hd;
		ticks_sent++;
	endtask

	task automatic send_random_tick();
		send_tick(next_count(sent_left), next_count(sent_right), next_heading(sent_imu));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pose_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DIST_PER_COUNT: dist_scale = val[DPC_W-1:0];
			REG_HEADING_OFFSET: head_zero = val[HEAD_W-1:0];
			REG_TICKS_PER_SECOND: tick_rate = val[TPS_W-1:0];
			default: ;
		endcase
		settings_used++;
		@(posedge clk);
	endtask

	task automatic test_first_step();
		// last counts are zero: the whole count is travel
		send_tick(32'd1000, 32'hFFFFFE0C, 16'h0000);
		send_tick(32'd1000, 32'hFFFFFE0C, 16'h0000);
	endtask

	task automatic test_count_extremes();
		send_tick(32'h7FFFFFFF, 32'h80000000, 16'h0000);
		send_tick(32'h80000000, 32'h7FFFFFFF, 16'h0000);
		send_tick(32'h00000000, 32'hFFFFFFFF, 16'h0000);
		send_tick(32'hFFFFFFFF, 32'h00000000, 16'h0000);
	endtask

	task automatic test_heading_wrap();
		logic [HEAD_W-1:0] seq [0:5];
		int k;
		seq = '{16'h0001, 16'hFFFF, 16'h8000, 16'h4000, 16'hC000, 16'h0000};
		for (k = 0; k < 6; k++) begin
			send_tick(sent_left + 32'd3000, sent_right + 32'd2900, seq[k]);
		end
	endtask

	task automatic test_position_saturation();
		int k;
		for (k = 0; k < 6; k++) begin
			send_tick(sent_left + 32'h7FFFFFFF, sent_right + 32'h7FFFFFFF,
				(k < 3) ? 16'h0000 : 16'h8000);
		end
	endtask

	task automatic test_register_writes();
		drain_results();
		write_reg(REG_TICKS_PER_SECOND, 24'd0);
		send_tick(sent_left + 32'd500, sent_right - 32'd700, 16'h1000);
		drain_results();
		write_reg(REG_DIST_PER_COUNT, 24'hFFFFFF);
		write_reg(REG_TICKS_PER_SECOND, 24'd16383);
		send_tick(sent_left + 32'd40000, sent_right + 32'd1, 16'h2000);
		drain_results();
		write_reg(REG_NONE, 24'h5A5A5A);
		send_tick(sent_left - 32'd1, sent_right + 32'd9, 16'h2100);
		drain_results();
		// upper data bits beyond the register width are dropped
		write_reg(REG_HEADING_OFFSET, 24'hABCDEF);
		write_reg(REG_TICKS_PER_SECOND, 24'hFFC123);
		send_tick(sent_left + 32'd77, sent_right + 32'd66, 16'hFFFF);
		drain_results();
		write_reg(REG_DIST_PER_COUNT, 24'd0);
		send_tick(sent_left + 32'd12345, sent_right - 32'd54321, 16'h0F0F);
		drain_results();
	endtask

	task automatic test_output_hold();
		int k;
		drain_results();
		write_reg(REG_DIST_PER_COUNT, DPC_RST);
		write_reg(REG_TICKS_PER_SECOND, TPS_RST);
		gap_max = 0;
		hold_req <= ~hold_req;
		for (k = 0; k < 12; k++) begin
			send_random_tick();
		end
		drain_results();
	endtask

	task automatic test_random_ticks();
		int ph, k;
		for (ph = 0; ph < 5; ph++) begin
			drain_results();
			case (ph)
				0: begin
					write_reg(REG_DIST_PER_COUNT, DPC_RST);
					write_reg(REG_HEADING_OFFSET, 24'd0);
					write_reg(REG_TICKS_PER_SECOND, TPS_RST);
					gap_max = 0;
				end
				1: begin
					write_reg(REG_DIST_PER_COUNT, 24'hFFFFFF);
					write_reg(REG_HEADING_OFFSET, 24'h00FFFF);
					write_reg(REG_TICKS_PER_SECOND, 24'd16383);
					gap_max = 4;
				end
				2: begin
					write_reg(REG_DIST_PER_COUNT, 24'd1);
					write_reg(REG_HEADING_OFFSET, 24'h001234);
					write_reg(REG_TICKS_PER_SECOND, 24'd1);
					gap_max = 30;
				end
				3: begin
					write_reg(REG_DIST_PER_COUNT, 24'($urandom));
					write_reg(REG_HEADING_OFFSET, 24'($urandom));
					write_reg(REG_TICKS_PER_SECOND, 24'($urandom_range(1, 10000)));
					gap_max = 12;
				end
				default: begin
					write_reg(REG_DIST_PER_COUNT, 24'($urandom_range(1, 4096)));
					write_reg(REG_HEADING_OFFSET, 24'($urandom));
					write_reg(REG_TICKS_PER_SECOND, 24'd10000);
					gap_max = 2;
				end
			endcase
			for (k = 0; k < 400; k++) begin
				send_random_tick();
			end
		end
	endtask

	// output side: random stall modes plus a long hold whenever hold_req toggles
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_cnt <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 2));
				mode_left <= $urandom_range(10, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				STALL_NONE: out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		pose_t want;
		if (arst_n && out_valid && !out_stall) begin
			poses_checked++;
			if (pose_expected.size() == 0) begin
				$display("%0t: result transfer with nothing expected", $time);
				fail_count++;
			end else begin
				want = pose_expected.pop_front();
				compare_field("pos_x", want.x, pos_x);
				compare_field("pos_y", want.y, pos_y);
				compare_field("pose_angle", want.angle, pose_angle);
				compare_field("vel_left", want.vl, vel_left);
				compare_field("vel_right", want.vr, vel_right);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_first_step();
		test_count_extremes();
		test_heading_wrap();
		test_position_saturation();
		test_register_writes();
		test_output_hold();
		test_random_ticks();
		drain_results();
		if (pose_expected.size() != 0) begin
			$display("%0d expected poses never arrived", pose_expected.size());
			fail_count++;
		end
		$display("Sent %0d ticks, checked %0d poses across %0d register writes,",
			ticks_sent, poses_checked, settings_used);
		$display("with input gaps, output stalls and one long output hold.");
		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

@@ diff_drive_odometry.f @@
hdl/ddo_pkg.sv
hdl/ddo_mul.sv
hdl/ddo_cordic.sv
hdl/diff_drive_odometry.sv
hdl/ddo_checker.sv
tb/tb_diff_drive_odometry.sv
